// ===== hdl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the ADC frame check and RTD conversion unit.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int REF_W      = 16;
  localparam int PROD_W     = SAMPLE_W + REF_W;
  localparam int DIVIDEND_W = PROD_W + 16;
  localparam int DIVISOR_W  = SAMPLE_W + 7;
  localparam int QUOT_W     = 36;
  localparam int RES_W      = 36;
  localparam int RTD1_RND_W = 35;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_XOR  = 8'hFF;

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  // Register indexes (byte address divided by four)
  localparam logic [2:0] REG_RTD1_GAIN   = 3'd0;
  localparam logic [2:0] REG_RTD2_GAIN   = 3'd1;
  localparam logic [2:0] REG_RTD1_REF    = 3'd2;
  localparam logic [2:0] REG_RTD2_REF    = 3'd3;
  localparam logic [2:0] REG_RTD1_OFFSET = 3'd4;
  localparam logic [2:0] REG_FAULT_THR   = 3'd5;

  localparam logic [2:0]  RST_RTD1_GAIN   = 3'd3;
  localparam logic [2:0]  RST_RTD2_GAIN   = 3'd4;
  localparam logic [15:0] RST_RTD1_REF    = 16'd1500;
  localparam logic [15:0] RST_RTD2_REF    = 16'd1000;
  localparam logic [15:0] RST_RTD1_OFFSET = 16'd100;
  localparam logic [7:0]  RST_FAULT_THR   = 8'd5;

  // Result status codes
  localparam logic [2:0] STAT_RTD1     = 3'd0;
  localparam logic [2:0] STAT_STORED   = 3'd1;
  localparam logic [2:0] STAT_RTD2     = 3'd2;
  localparam logic [2:0] STAT_UNKNOWN  = 3'd3;
  localparam logic [2:0] STAT_CRC_ERR  = 3'd4;
  localparam logic [2:0] STAT_LINK_ERR = 3'd5;
  localparam logic [2:0] STAT_DIV_ZERO = 3'd6;

  // Decoded channel codes
  localparam logic [1:0] CH_RTD1    = 2'd0;
  localparam logic [1:0] CH_STORE   = 2'd1;
  localparam logic [1:0] CH_RTD2    = 2'd2;
  localparam logic [1:0] CH_UNKNOWN = 2'd3;

  typedef struct packed {
    logic       link_ok;
    logic [7:0] flags_byte;
    logic [7:0] data_high;
    logic [7:0] data_mid;
    logic [7:0] data_low;
    logic [7:0] crc_byte;
  } frame_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [1:0]       channel;
    logic [23:0]      raw_value;
    logic [RES_W-1:0] resistance;
    logic             fault;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_PREP,
    S_LAUNCH,
    S_DIVWAIT,
    S_FINISH
  } state_t;

endpackage

// ===== hdl/afc_stream_if.sv =====
// ----------------------------------------------------------------------------
// afc_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface afc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/afc_crc_serial.sv =====
// ----------------------------------------------------------------------------
// afc_crc_serial
// Bit-serial CRC-8 (polynomial 0x31, zero init) over the 24 data bits.
// ----------------------------------------------------------------------------
module afc_crc_serial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [23:0]           data,
  output logic [7:0]            crc,
  output afc_pkg::unit_status_t stat
);

  logic [23:0] shreg;
  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic        top;
  logic [7:0]  crc_next;

  // One data bit per cycle, most significant bit first.
  assign top      = shreg[23] ^ crc[7];
  assign crc_next = {crc[6:0], 1'b0} ^ (top ? afc_pkg::CRC_POLY : 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= data;
      crc   <= '0;
    end else if (busy) begin
      shreg <= {shreg[22:0], 1'b0};
      crc   <= crc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/afc_mul_serial.sv =====
// ----------------------------------------------------------------------------
// afc_mul_serial
// Shift-and-add multiplier taking one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module afc_mul_serial (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [afc_pkg::SAMPLE_W-1:0] a,
  input  logic [afc_pkg::REF_W-1:0]    b,
  output logic [afc_pkg::PROD_W-1:0]   prod,
  output afc_pkg::unit_status_t        stat
);

  logic [afc_pkg::REF_W-1:0]    bsh;
  logic [afc_pkg::SAMPLE_W-1:0] areg;
  logic [3:0]                   count;
  logic                         busy;
  logic                         done;
  logic [afc_pkg::SAMPLE_W:0]   sum;

  // The accumulator shifts right, so only its upper part takes the addend.
  assign sum = {1'b0, prod[afc_pkg::PROD_W-1:afc_pkg::REF_W]}
             + (bsh[0] ? {1'b0, areg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      bsh  <= b;
      prod <= '0;
    end else if (busy) begin
      bsh  <= {1'b0, bsh[afc_pkg::REF_W-1:1]};
      prod <= {sum, prod[afc_pkg::REF_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/afc_div_serial.sv =====
// ----------------------------------------------------------------------------
// afc_div_serial
// Restoring divider producing one quotient bit per cycle, with overflow check.
// ----------------------------------------------------------------------------
module afc_div_serial (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [afc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [afc_pkg::DIVISOR_W-1:0]  divisor,
  output logic [afc_pkg::QUOT_W-1:0]     quot,
  output logic                           ovf,
  output afc_pkg::unit_status_t          stat
);

  localparam int HI_W = afc_pkg::DIVIDEND_W - afc_pkg::QUOT_W;

  logic [afc_pkg::DIVISOR_W-1:0] rem;
  logic [afc_pkg::DIVISOR_W-1:0] den;
  logic [afc_pkg::DIVISOR_W-1:0] hi_ext;
  logic [afc_pkg::DIVISOR_W:0]   trial;
  logic [afc_pkg::DIVISOR_W:0]   diff;
  logic                          ge;
  logic [5:0]                    count;
  logic                          busy;
  logic                          done;

  // The quotient fits its width exactly when the upper dividend bits stay
  // below the divisor.
  assign hi_ext = {{(afc_pkg::DIVISOR_W-HI_W){1'b0}},
                   dividend[afc_pkg::DIVIDEND_W-1:afc_pkg::QUOT_W]};

  assign trial = {rem, quot[afc_pkg::QUOT_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == 6'(afc_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= hi_ext;
      quot <= dividend[afc_pkg::QUOT_W-1:0];
      den  <= divisor;
      ovf  <= (hi_ext >= divisor);
    end else if (busy) begin
      rem  <= ge ? diff[afc_pkg::DIVISOR_W-1:0] : trial[afc_pkg::DIVISOR_W-1:0];
      quot <= {quot[afc_pkg::QUOT_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/adc_frame_check_rtd_convert_unit.sv =====
// ----------------------------------------------------------------------------
// adc_frame_check_rtd_convert_unit
// Checks converter readout frames and converts samples to RTD resistances.
// ----------------------------------------------------------------------------
// One frame is worked on at a time. A frame with a link error goes
// straight to the result stage; any other frame is gated by the
// bit-serial CRC over the 24 data bits, while the serial multiplier
// also forms the product. A valid channel 2 frame with a nonzero sample
// then runs the restoring divider for 36 quotient bits. A finished
// result waits in an output register, and the next frame is accepted
// while it waits.
module adc_frame_check_rtd_convert_unit (
  input  logic        clk,
  input  logic        rst,
  afc_stream_if.sink   frame,
  afc_stream_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [2:0]  rtd1_gain_log2;
  logic [2:0]  rtd2_gain_log2;
  logic [15:0] rtd1_ref_ohms;
  logic [15:0] rtd2_ref_ohms;
  logic [15:0] rtd1_offset_ohms;
  logic [7:0]  fault_threshold;

  logic [afc_pkg::SAMPLE_W-1:0] stored_sample;
  logic [7:0]                   bad_count;

  afc_pkg::state_t state, state_next;

  afc_pkg::frame_t  cur;
  afc_pkg::result_t res;
  logic             res_valid;

  logic accept;
  logic unit_start;
  logic div_start;
  logic load;
  logic cfg_write;

  logic [1:0]                   in_chan;
  logic [1:0]                   cur_chan;
  logic [afc_pkg::SAMPLE_W-1:0] in_raw;
  logic [afc_pkg::SAMPLE_W-1:0] raw;
  logic                         crc_ok;
  logic                         bad;

  logic [7:0]                     crc;
  afc_pkg::unit_status_t          crc_stat;
  logic [afc_pkg::SAMPLE_W-1:0]   mul_a;
  logic [afc_pkg::REF_W-1:0]      mul_b;
  logic [afc_pkg::PROD_W-1:0]     prod;
  afc_pkg::unit_status_t          mul_stat;
  logic [afc_pkg::QUOT_W-1:0]     quot;
  logic                           div_ovf;
  afc_pkg::unit_status_t          div_stat;

  logic [3:0]                       rtd1_shift;
  logic [afc_pkg::PROD_W:0]         rtd1_sum;
  logic [afc_pkg::PROD_W:0]         rtd1_shifted;
  logic [afc_pkg::RTD1_RND_W-1:0]   rtd1_round;
  logic [afc_pkg::DIVIDEND_W-1:0]   dividend;
  logic [afc_pkg::DIVISOR_W-1:0]    divisor;
  logic [afc_pkg::DIVISOR_W-1:0]    den_calc;

  logic [7:0]  bad_count_inc;
  logic [7:0]  bad_count_next;
  logic        fault_next;
  logic [2:0]  status_next;
  logic [1:0]  channel_next;
  logic [afc_pkg::RES_W-1:0] resistance_next;

  // ---------------------------------------------------------------- APB port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtd1_gain_log2   <= afc_pkg::RST_RTD1_GAIN;
      rtd2_gain_log2   <= afc_pkg::RST_RTD2_GAIN;
      rtd1_ref_ohms    <= afc_pkg::RST_RTD1_REF;
      rtd2_ref_ohms    <= afc_pkg::RST_RTD2_REF;
      rtd1_offset_ohms <= afc_pkg::RST_RTD1_OFFSET;
      fault_threshold  <= afc_pkg::RST_FAULT_THR;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        afc_pkg::REG_RTD1_GAIN:   rtd1_gain_log2   <= pwdata[2:0];
        afc_pkg::REG_RTD2_GAIN:   rtd2_gain_log2   <= pwdata[2:0];
        afc_pkg::REG_RTD1_REF:    rtd1_ref_ohms    <= pwdata[15:0];
        afc_pkg::REG_RTD2_REF:    rtd2_ref_ohms    <= pwdata[15:0];
        afc_pkg::REG_RTD1_OFFSET: rtd1_offset_ohms <= pwdata[15:0];
        afc_pkg::REG_FAULT_THR:   fault_threshold  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      afc_pkg::REG_RTD1_GAIN:   prdata = {29'd0, rtd1_gain_log2};
      afc_pkg::REG_RTD2_GAIN:   prdata = {29'd0, rtd2_gain_log2};
      afc_pkg::REG_RTD1_REF:    prdata = {16'd0, rtd1_ref_ohms};
      afc_pkg::REG_RTD2_REF:    prdata = {16'd0, rtd2_ref_ohms};
      afc_pkg::REG_RTD1_OFFSET: prdata = {16'd0, rtd1_offset_ohms};
      afc_pkg::REG_FAULT_THR:   prdata = {24'd0, fault_threshold};
      default:                  prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------ frame decode
  assign in_raw  = {frame.payload.data_high, frame.payload.data_mid,
                    frame.payload.data_low};
  assign in_chan = (frame.payload.flags_byte[2:0] <= 3'd2)
                 ? frame.payload.flags_byte[1:0] : afc_pkg::CH_UNKNOWN;

  assign raw      = {cur.data_high, cur.data_mid, cur.data_low};
  assign cur_chan = (cur.flags_byte[2:0] <= 3'd2) ? cur.flags_byte[1:0]
                                                  : afc_pkg::CH_UNKNOWN;
  assign crc_ok   = ((crc ^ afc_pkg::CRC_XOR) == cur.crc_byte);
  assign bad      = !cur.link_ok || !crc_ok;

  assign frame.ready = (state == afc_pkg::S_IDLE);
  assign accept      = frame.valid & frame.ready;
  assign unit_start  = accept & frame.payload.link_ok;

  // Channel 2 multiplies the stored sample by its reference; channel 0 the
  // fresh sample by the first reference.
  assign mul_a = (in_chan == afc_pkg::CH_RTD2) ? stored_sample : in_raw;
  assign mul_b = (in_chan == afc_pkg::CH_RTD2) ? rtd2_ref_ohms : rtd1_ref_ohms;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= frame.payload;
    end
  end

  afc_crc_serial u_crc (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .data  (in_raw),
    .crc   (crc),
    .stat  (crc_stat)
  );

  afc_mul_serial u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .stat  (mul_stat)
  );

  afc_div_serial u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quot     (quot),
    .ovf      (div_ovf),
    .stat     (div_stat)
  );

  // ------------------------------------------------------- operand shaping
  assign rtd1_shift   = 4'd6 + {1'b0, rtd1_gain_log2};
  assign rtd1_sum     = {1'b0, prod} + ((afc_pkg::PROD_W+1)'(1) << (rtd1_shift - 4'd1));
  assign rtd1_shifted = rtd1_sum >> rtd1_shift;
  assign den_calc     = afc_pkg::DIVISOR_W'(raw) << rtd2_gain_log2;

  always_ff @(posedge clk) begin
    if (state == afc_pkg::S_PREP && !mul_stat.busy) begin
      rtd1_round <= rtd1_shifted[afc_pkg::RTD1_RND_W-1:0];
      divisor    <= den_calc;
      dividend   <= {prod, 16'd0}
                  + afc_pkg::DIVIDEND_W'(den_calc[afc_pkg::DIVISOR_W-1:1]);
    end
  end

  // ---------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state)
      afc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = frame.payload.link_ok ? afc_pkg::S_RUN : afc_pkg::S_FINISH;
        end
      end
      afc_pkg::S_RUN: begin
        if (crc_stat.done) begin
          state_next = afc_pkg::S_PREP;
        end
      end
      afc_pkg::S_PREP: begin
        if (!mul_stat.busy) begin
          if (crc_ok && cur_chan == afc_pkg::CH_RTD2 && raw != '0) begin
            state_next = afc_pkg::S_LAUNCH;
          end else begin
            state_next = afc_pkg::S_FINISH;
          end
        end
      end
      afc_pkg::S_LAUNCH: begin
        div_start  = 1'b1;
        state_next = afc_pkg::S_DIVWAIT;
      end
      afc_pkg::S_DIVWAIT: begin
        if (div_stat.done) begin
          state_next = afc_pkg::S_FINISH;
        end
      end
      afc_pkg::S_FINISH: begin
        if (!res_valid || result.ready) begin
          load       = 1'b1;
          state_next = afc_pkg::S_IDLE;
        end
      end
      default: state_next = afc_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------- result assembly
  assign bad_count_inc = bad_count + 8'd1;

  always_comb begin
    bad_count_next = bad_count;
    fault_next     = 1'b0;
    if (bad) begin
      if (bad_count != 8'hFF) begin
        bad_count_next = bad_count_inc;
        fault_next     = (bad_count_inc == fault_threshold);
      end
    end else begin
      bad_count_next = '0;
    end
  end

  always_comb begin
    channel_next    = cur_chan;
    resistance_next = '0;
    priority if (!cur.link_ok) begin
      status_next  = afc_pkg::STAT_LINK_ERR;
      channel_next = afc_pkg::CH_UNKNOWN;
    end else if (!crc_ok) begin
      status_next = afc_pkg::STAT_CRC_ERR;
    end else begin
      unique case (cur_chan)
        afc_pkg::CH_RTD1: begin
          status_next     = afc_pkg::STAT_RTD1;
          resistance_next = afc_pkg::RES_W'(rtd1_round)
                          + {4'd0, rtd1_offset_ohms, 16'd0};
        end
        afc_pkg::CH_STORE: begin
          status_next = afc_pkg::STAT_STORED;
        end
        afc_pkg::CH_RTD2: begin
          if (raw == '0) begin
            status_next     = afc_pkg::STAT_DIV_ZERO;
            resistance_next = afc_pkg::RES_MAX;
          end else begin
            status_next     = afc_pkg::STAT_RTD2;
            resistance_next = div_ovf ? afc_pkg::RES_MAX : quot;
          end
        end
        default: begin
          status_next = afc_pkg::STAT_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      bad_count     <= '0;
      stored_sample <= '0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        bad_count <= bad_count_next;
        if (!bad && cur_chan == afc_pkg::CH_STORE) begin
          stored_sample <= raw;
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.status     <= status_next;
      res.channel    <= channel_next;
      res.raw_value  <= bad ? '0 : raw;
      res.resistance <= resistance_next;
      res.fault      <= fault_next;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res;

endmodule

// ===== dv/adc_frame_check_rtd_convert_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_check_rtd_convert_unit_tb
// Self-checking bench for the frame checker and RTD converter. Frames are
// driven over the valid/ready input and predicted by an independent model of
// the CRC check, sample assembly, RTD arithmetic and bad-frame counter. Every
// result transaction is compared with the oldest prediction. Registers are
// written and read back over APB between traffic phases.
// ----------------------------------------------------------------------------
module adc_frame_check_rtd_convert_unit_tb;

  localparam logic [2:0] REG_UNUSED   = 3'd6;
  localparam int         MAX_REPORTS  = 10;
  localparam int         DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  afc_stream_if #(.payload_t(afc_pkg::frame_t))  frame_if ();
  afc_stream_if #(.payload_t(afc_pkg::result_t)) result_if ();

  adc_frame_check_rtd_convert_unit dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_if.sink),
    .result  (result_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted register contents and converter state.
  logic [2:0]  gain1_log2;
  logic [2:0]  gain2_log2;
  logic [15:0] ref1_ohms;
  logic [15:0] ref2_ohms;
  logic [15:0] offset1_ohms;
  logic [7:0]  fault_thr;
  logic [23:0] channel1_sample;
  logic [7:0]  bad_run;

  afc_pkg::result_t pending_results[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] frame_crc(input logic [23:0] data);
    logic [7:0] crc;
    int         i;
    crc = 8'h00;
    for (i = 23; i >= 0; i--) begin
      if (data[i] ^ crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ afc_pkg::CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc ^ afc_pkg::CRC_XOR;
  endfunction

  function automatic logic [afc_pkg::RES_W-1:0] saturate_res(input logic [63:0] v);
    return (v > 64'(afc_pkg::RES_MAX)) ? afc_pkg::RES_MAX : v[afc_pkg::RES_W-1:0];
  endfunction

  // Works out the result of one frame and advances the predicted state.
  function automatic afc_pkg::result_t predict_result(input afc_pkg::frame_t f);
    afc_pkg::result_t r;
    logic [2:0]  sel;
    logic [63:0] prod;
    logic [63:0] num;
    logic [63:0] den;
    logic        bad;
    int          shift;
    sel          = f.flags_byte[2:0];
    r.status     = afc_pkg::STAT_UNKNOWN;
    r.channel    = (sel <= 3'd2) ? sel[1:0] : afc_pkg::CH_UNKNOWN;
    r.raw_value  = '0;
    r.resistance = '0;
    r.fault      = 1'b0;
    bad          = 1'b0;
    if (!f.link_ok) begin
      r.status  = afc_pkg::STAT_LINK_ERR;
      r.channel = afc_pkg::CH_UNKNOWN;
      bad       = 1'b1;
    end else if (frame_crc({f.data_high, f.data_mid, f.data_low}) != f.crc_byte) begin
      r.status = afc_pkg::STAT_CRC_ERR;
      bad      = 1'b1;
    end else begin
      r.raw_value = {f.data_high, f.data_mid, f.data_low};
      case (r.channel)
        afc_pkg::CH_RTD1: begin
          shift        = 6 + int'(gain1_log2);
          prod         = 64'(ref1_ohms) * 64'(r.raw_value);
          prod         = (prod + (64'd1 << (shift - 1))) >> shift;
          r.resistance = saturate_res(prod + (64'(offset1_ohms) << 16));
          r.status     = afc_pkg::STAT_RTD1;
        end
        afc_pkg::CH_STORE: begin
          channel1_sample = r.raw_value;
          r.status        = afc_pkg::STAT_STORED;
        end
        afc_pkg::CH_RTD2: begin
          if (r.raw_value == 24'd0) begin
            r.status     = afc_pkg::STAT_DIV_ZERO;
            r.resistance = afc_pkg::RES_MAX;
          end else begin
            num          = (64'(channel1_sample) * 64'(ref2_ohms)) << 16;
            den          = 64'(r.raw_value) << gain2_log2;
            r.resistance = saturate_res((num + (den >> 1)) / den);
            r.status     = afc_pkg::STAT_RTD2;
          end
        end
        default: r.status = afc_pkg::STAT_UNKNOWN;
      endcase
    end
    if (bad) begin
      if (bad_run < 8'd255) begin
        bad_run = bad_run + 8'd1;
        if (bad_run == fault_thr) r.fault = 1'b1;
      end
    end else begin
      bad_run = '0;
    end
    return r;
  endfunction

  function automatic afc_pkg::frame_t make_frame(input logic [7:0] flags,
                                                 input logic [23:0] data);
    afc_pkg::frame_t f;
    f.link_ok    = 1'b1;
    f.flags_byte = flags;
    f.data_high  = data[23:16];
    f.data_mid   = data[15:8];
    f.data_low   = data[7:0];
    f.crc_byte   = frame_crc(data);
    return f;
  endfunction

  // A frame that counts as bad: either the link failed or the CRC is off.
  function automatic afc_pkg::frame_t broken_frame();
    afc_pkg::frame_t f;
    f = make_frame(8'($urandom), 24'($urandom));
    if ($urandom_range(1)) begin
      f.link_ok = 1'b0;
      f.crc_byte = 8'($urandom);
    end else begin
      f.crc_byte = f.crc_byte ^ 8'($urandom_range(255, 1));
    end
    return f;
  endfunction

  function automatic afc_pkg::frame_t random_frame();
    afc_pkg::frame_t f;
    logic [2:0]  sel;
    logic [23:0] data;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 35) sel = 3'd0;
    else if (pick < 60) sel = 3'd1;
    else if (pick < 90) sel = 3'd2;
    else sel = 3'($urandom_range(7, 3));
    pick = $urandom_range(99);
    if (pick < 8) data = '0;
    else if (pick < 16) data = '1;
    else if (pick < 30) data = 24'($urandom_range(255));
    else data = 24'($urandom);
    f    = make_frame({5'($urandom), sel}, data);
    pick = $urandom_range(99);
    if (pick < 5) begin
      f.link_ok  = 1'b0;
      f.crc_byte = 8'($urandom);
    end else if (pick < 12) begin
      f.crc_byte = f.crc_byte ^ 8'($urandom_range(255, 1));
    end
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_frame(input afc_pkg::frame_t f);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
    frame_if.valid   <= 1'b1;
    frame_if.payload <= f;
    do @(posedge clk); while (!frame_if.ready);
    pending_results.push_back(predict_result(f));
  endtask

  task automatic wait_for_results();
    int guard;
    @(negedge clk);
    frame_if.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      afc_pkg::REG_RTD1_GAIN:   gain1_log2   = value[2:0];
      afc_pkg::REG_RTD2_GAIN:   gain2_log2   = value[2:0];
      afc_pkg::REG_RTD1_REF:    ref1_ohms    = value[15:0];
      afc_pkg::REG_RTD2_REF:    ref2_ohms    = value[15:0];
      afc_pkg::REG_RTD1_OFFSET: offset1_ohms = value[15:0];
      afc_pkg::REG_FAULT_THR:   fault_thr    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [31:0] want, input int width);
    logic [31:0] got;
    logic [31:0] mask;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    mask = (32'd1 << width) - 32'd1;
    if ((got & mask) !== (want & mask)) begin
      report_mismatch($sformatf("register %0d read expected %h actual %h", idx, want & mask,
                                got & mask));
    end
  endtask

  task automatic check_registers();
    check_reg(afc_pkg::REG_RTD1_GAIN, 32'(gain1_log2), 3);
    check_reg(afc_pkg::REG_RTD2_GAIN, 32'(gain2_log2), 3);
    check_reg(afc_pkg::REG_RTD1_REF, 32'(ref1_ohms), 16);
    check_reg(afc_pkg::REG_RTD2_REF, 32'(ref2_ohms), 16);
    check_reg(afc_pkg::REG_RTD1_OFFSET, 32'(offset1_ohms), 16);
    check_reg(afc_pkg::REG_FAULT_THR, 32'(fault_thr), 8);
  endtask

  task automatic set_config(input int g1, input int g2, input int r1, input int r2,
                            input int off, input int thr);
    write_reg(afc_pkg::REG_RTD1_GAIN, 32'(g1));
    write_reg(afc_pkg::REG_RTD2_GAIN, 32'(g2));
    write_reg(afc_pkg::REG_RTD1_REF, 32'(r1));
    write_reg(afc_pkg::REG_RTD2_REF, 32'(r2));
    write_reg(afc_pkg::REG_RTD1_OFFSET, 32'(off));
    write_reg(afc_pkg::REG_FAULT_THR, 32'(thr));
    check_registers();
  endtask

  // Receiver: random idling, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles     <= hold_cycles - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    afc_pkg::result_t want;
    afc_pkg::result_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result transaction with none outstanding: %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.channel !== want.channel ||
            got.raw_value !== want.raw_value || got.resistance !== want.resistance ||
            got.fault !== want.fault) begin
          report_mismatch($sformatf(
            "status %0d/%0d channel %0d/%0d raw %h/%h res %h/%h fault %0d/%0d (exp/act)",
            want.status, got.status, want.channel, got.channel, want.raw_value,
            got.raw_value, want.resistance, got.resistance, want.fault, got.fault));
        end
      end
    end
  end

  task automatic test_directed_frames();
    afc_pkg::frame_t f;
    int     sel;
    send_idle_pct = 10;
    recv_idle_pct = 30;
    send_frame(make_frame(8'h00, 24'h000000));
    send_frame(make_frame(8'hF8, 24'hFFFFFF));
    send_frame(make_frame(8'h00, 24'h000001));
    send_frame(make_frame(8'h00, 24'h000020));
    // Ratio against a stored sample of zero, then against the largest one.
    send_frame(make_frame(8'h01, 24'h000000));
    send_frame(make_frame(8'h02, 24'h123456));
    send_frame(make_frame(8'hF9, 24'hFFFFFF));
    send_frame(make_frame(8'h02, 24'h000001));
    send_frame(make_frame(8'hFA, 24'hFFFFFF));
    send_frame(make_frame(8'h02, 24'h000000));
    for (sel = 3; sel <= 7; sel++) begin
      send_frame(make_frame({5'b10101, 3'(sel)}, 24'($urandom)));
    end
    f = make_frame(8'h00, 24'hABCDEF);
    f.crc_byte = f.crc_byte ^ 8'h80;
    send_frame(f);
    f = make_frame(8'h02, 24'h00FF00);
    f.crc_byte = f.crc_byte ^ 8'h01;
    send_frame(f);
    f = make_frame(8'hFF, 24'hFFFFFF);
    f.link_ok  = 1'b0;
    f.crc_byte = 8'hFF;
    send_frame(f);
    f = make_frame(8'h00, 24'h000000);
    f.link_ok  = 1'b0;
    f.crc_byte = 8'h00;
    send_frame(f);
    send_frame(make_frame(8'h01, 24'h800000));
    send_frame(make_frame(8'h02, 24'h400000));
    wait_for_results();
  endtask

  task automatic test_register_access();
    set_config(7, 7, 65535, 65535, 65535, 255);
    set_config(0, 0, 1, 1, 0, 1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    check_registers();
    set_config(afc_pkg::RST_RTD1_GAIN, afc_pkg::RST_RTD2_GAIN, afc_pkg::RST_RTD1_REF,
               afc_pkg::RST_RTD2_REF, afc_pkg::RST_RTD1_OFFSET, afc_pkg::RST_FAULT_THR);
  endtask

  task automatic test_fault_counter();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(afc_pkg::REG_FAULT_THR, 32'd3);
    repeat (5) send_frame(broken_frame());
    send_frame(random_frame());
    send_frame(make_frame(8'h00, 24'h010203));
    repeat (3) send_frame(broken_frame());
    send_frame(make_frame(8'h01, 24'h0A0B0C));
    wait_for_results();
    // Counter runs up to its ceiling; the pulse must come once, at 255.
    write_reg(afc_pkg::REG_FAULT_THR, 32'd255);
    repeat (258) send_frame(broken_frame());
    send_frame(make_frame(8'h00, 24'h00FFFF));
    wait_for_results();
    write_reg(afc_pkg::REG_FAULT_THR, 32'd0);
    repeat (10) send_frame(broken_frame());
    send_frame(make_frame(8'h01, 24'h0000FF));
    wait_for_results();
    write_reg(afc_pkg::REG_FAULT_THR, 32'd1);
    repeat (2) send_frame(broken_frame());
    send_frame(make_frame(8'h00, 24'h000100));
    send_frame(broken_frame());
    wait_for_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_cycles = 300;
    repeat (10) send_frame(random_frame());
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
    int sent;
    int burst;
    int burst_max;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    burst_max = (fault_thr != 8'd0 && fault_thr < 8'd20) ? int'(fault_thr) + 1 : 20;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 3) begin
        burst = $urandom_range(burst_max, 1);
        repeat (burst) send_frame(broken_frame());
        sent += burst;
      end else begin
        send_frame(random_frame());
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    frame_if.valid    = 1'b0;
    frame_if.payload  = '0;
    result_if.ready   = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_cycles       = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    mismatches        = 0;
    gain1_log2        = afc_pkg::RST_RTD1_GAIN;
    gain2_log2        = afc_pkg::RST_RTD2_GAIN;
    ref1_ohms         = afc_pkg::RST_RTD1_REF;
    ref2_ohms         = afc_pkg::RST_RTD2_REF;
    offset1_ohms      = afc_pkg::RST_RTD1_OFFSET;
    fault_thr         = afc_pkg::RST_FAULT_THR;
    channel1_sample   = '0;
    bad_run           = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_register_access();
    test_fault_counter();
    test_backpressure();
    set_config(0, 7, 65535, 1, 65535, 1);
    test_random_traffic(245, 21, 68);
    set_config(7, 0, 1, 65535, 0, 255);
    test_random_traffic(245, 68, 21);
    set_config($urandom_range(7), $urandom_range(7), $urandom_range(65535, 1),
               $urandom_range(65535, 1), $urandom_range(65535), $urandom_range(12, 2));
    test_random_traffic(245, 0, 0);

    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
